@@ hw/rtl/fp8q_pkg.sv @@
// shared constants and control types for the fp8 e4m3 block quantizer
package fp8q_pkg;

    localparam int BLOCK_SIZE_DEF = 256;
    localparam int CODES_PER_RESULT_DEF = 8;

    localparam logic [31:0] F32_240 = 32'h4370_0000;
    localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] F32_INF = 32'h7F80_0000;
    localparam logic [31:0] F32_E4M3_MIN_NORM = 32'h3C80_0000;

    localparam logic [6:0] E4M3_NAN = 7'h7F;
    localparam logic [6:0] E4M3_INF = 7'h78;
    localparam logic [6:0] E4M3_MAX = 7'h77;

    typedef struct packed {
        logic wr;
        logic rd;
        logic div_start;
        logic div_scale;
        logic code_wr;
        logic code_zero;
        logic load_scale;
        logic clear_amax;
        logic clear_packed;
    } fp8q_cmd_t;

    typedef struct packed {
        logic div_done;
        logic d_zero;
    } fp8q_stat_t;

endpackage

@@ hw/rtl/fp8q_in_if.sv @@
// input channel: one fp32 value per beat
interface fp8q_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;

    modport source (output valid, output value_bits, input ready);
    modport sink (input valid, input value_bits, output ready);
endinterface

@@ hw/rtl/fp8q_out_if.sv @@
// output channel: one group of e4m3 codes with the block scale per beat
interface fp8q_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] codes_packed;
    logic [31:0] scale_bits;
    logic        last_of_block;

    modport source (output valid, output codes_packed, output scale_bits,
                    output last_of_block, input ready);
    modport sink (input valid, input codes_packed, input scale_bits,
                  input last_of_block, output ready);
endinterface

@@ hw/rtl/fp8q_ram.sv @@
// generic single write port ram with registered read
module fp8q_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/fp8q_fdiv.sv @@
// iterative ieee single precision divider, one quotient bit per cycle
module fp8q_fdiv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] result
);
    import fp8q_pkg::*;

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_PRE  = 3'd1;
    localparam logic [2:0] D_DIV  = 3'd2;
    localparam logic [2:0] D_NORM = 3'd3;
    localparam logic [2:0] D_RND  = 3'd4;

    logic [2:0]         state_reg;
    logic               done_reg;
    logic [4:0]         cnt_reg;
    logic               sign_reg;
    logic [23:0]        ma_reg;
    logic [23:0]        mb_reg;
    logic signed [10:0] ea_reg;
    logic signed [10:0] eb_reg;
    logic [25:0]        rem_reg;
    logic [26:0]        q_reg;
    logic [26:0]        n_reg;
    logic signed [10:0] be_reg;
    logic               sticky_reg;
    logic [31:0]        res_reg;

    logic [7:0]  a_exp;
    logic [7:0]  b_exp;
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    logic        a_zero;
    logic        b_zero;
    logic        s;
    logic        special;
    logic [31:0] spec_res;

    logic        ge;
    logic [25:0] rem_sel;
    logic [25:0] rem_shift;
    logic signed [10:0] e_diff;

    logic signed [10:0] sh_full;
    logic [26:0] keep;
    logic        lost;
    logic [7:0]  expf;
    logic        inc;
    logic [30:0] rounded;
    logic [31:0] rnd_res;

    assign a_exp  = a[30:23];
    assign b_exp  = b[30:23];
    assign a_nan  = (a_exp == 8'hFF) && (a[22:0] != 23'd0);
    assign b_nan  = (b_exp == 8'hFF) && (b[22:0] != 23'd0);
    assign a_inf  = (a_exp == 8'hFF) && (a[22:0] == 23'd0);
    assign b_inf  = (b_exp == 8'hFF) && (b[22:0] == 23'd0);
    assign a_zero = (a[30:0] == 31'd0);
    assign b_zero = (b[30:0] == 31'd0);
    assign s      = a[31] ^ b[31];
    assign special = a_nan | b_nan | a_inf | b_inf | a_zero | b_zero;

    always_comb
    begin
        if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero))
        begin
            spec_res = F32_QNAN;
        end
        else if (a_inf || b_zero)
        begin
            spec_res = {s, F32_INF[30:0]};
        end
        else
        begin
            spec_res = {s, 31'd0};
        end
    end

    assign ge        = (rem_reg >= {2'b00, mb_reg});
    assign rem_sel   = ge ? (rem_reg - {2'b00, mb_reg}) : rem_reg;
    assign rem_shift = {rem_sel[24:0], 1'b0};
    assign e_diff    = ea_reg - eb_reg;

    // final alignment, subnormal shift and round to nearest even
    always_comb
    begin
        sh_full = 11'sd1 - be_reg;
        keep    = n_reg;
        lost    = 1'b0;
        expf    = 8'd0;
        if (be_reg >= 11'sd1)
        begin
            expf = be_reg[7:0];
        end
        else if (sh_full >= 11'sd27)
        begin
            keep = 27'd0;
            lost = |n_reg;
        end
        else
        begin
            keep = n_reg >> sh_full[4:0];
            lost = |(n_reg & ~(27'h7FF_FFFF << sh_full[4:0]));
        end
        inc     = keep[2] & (keep[3] | keep[1] | keep[0] | lost | sticky_reg);
        rounded = {expf, keep[25:3]} + {30'd0, inc};
        if (be_reg >= 11'sd255)
        begin
            rnd_res = {sign_reg, F32_INF[30:0]};
        end
        else
        begin
            rnd_res = {sign_reg, rounded};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        if (special)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= D_PRE;
                        end
                    end
                end
                D_PRE:
                begin
                    if (ma_reg[23] && mb_reg[23])
                    begin
                        cnt_reg   <= 5'd0;
                        state_reg <= D_DIV;
                    end
                end
                D_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd26)
                    begin
                        state_reg <= D_NORM;
                    end
                end
                D_NORM:
                begin
                    state_reg <= D_RND;
                end
                D_RND:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    res_reg  <= spec_res;
                    sign_reg <= s;
                    ma_reg   <= {a_exp != 8'd0, a[22:0]};
                    mb_reg   <= {b_exp != 8'd0, b[22:0]};
                    ea_reg   <= (a_exp == 8'd0) ? 11'sd1 : $signed({3'b000, a_exp});
                    eb_reg   <= (b_exp == 8'd0) ? 11'sd1 : $signed({3'b000, b_exp});
                end
            end
            D_PRE:
            begin
                rem_reg <= {2'b00, ma_reg};
                q_reg   <= 27'd0;
                if (!ma_reg[23])
                begin
                    ma_reg <= {ma_reg[22:0], 1'b0};
                    ea_reg <= ea_reg - 11'sd1;
                end
                if (!mb_reg[23])
                begin
                    mb_reg <= {mb_reg[22:0], 1'b0};
                    eb_reg <= eb_reg - 11'sd1;
                end
            end
            D_DIV:
            begin
                q_reg   <= {q_reg[25:0], ge};
                rem_reg <= rem_shift;
            end
            D_NORM:
            begin
                sticky_reg <= |rem_reg;
                if (q_reg[26])
                begin
                    n_reg  <= q_reg;
                    be_reg <= e_diff + 11'sd127;
                end
                else
                begin
                    n_reg  <= {q_reg[25:0], 1'b0};
                    be_reg <= e_diff + 11'sd126;
                end
            end
            D_RND:
            begin
                res_reg <= rnd_res;
            end
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ hw/rtl/fp8q_datapath.sv @@
// datapath: sample ram, running amax, scale, divider and e4m3 encoder
module fp8q_datapath #(
    parameter int BLOCK_SIZE = fp8q_pkg::BLOCK_SIZE_DEF,
    parameter int CODES_PER_RESULT = fp8q_pkg::CODES_PER_RESULT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fp8q_pkg::fp8q_cmd_t                 cmd,
    output fp8q_pkg::fp8q_stat_t                stat,
    input  logic [$clog2(BLOCK_SIZE)-1:0]       addr,
    input  logic [((CODES_PER_RESULT > 1) ? $clog2(CODES_PER_RESULT) : 1)-1:0] slot,
    input  logic [31:0]                         value_bits,
    output logic [63:0]                         codes_packed,
    output logic [31:0]                         scale_bits
);
    import fp8q_pkg::*;

    logic [30:0] amax_reg;
    logic [31:0] d_reg;
    logic [63:0] packed_reg;

    logic [31:0] rd_data;
    logic [31:0] div_a;
    logic [31:0] div_b;
    logic        div_done;
    logic [31:0] div_res;
    logic [7:0]  code;
    logic [5:0]  byte_pos;

    function automatic logic [7:0] enc_e4m3(input logic [31:0] q, input logic xs);
        logic [30:0] mag;
        logic        sg;
        logic [7:0]  e;
        logic [23:0] m24;
        logic [8:0]  shv;
        logic [3:0]  mr;
        logic [7:0]  e8;
        logic [7:0]  r;
        mag = q[30:0];
        sg  = q[31];
        e   = q[30:23];
        m24 = {e != 8'd0, q[22:0]};
        shv = 9'd141 - {1'b0, ((e == 8'd0) ? 8'd1 : e)};
        e8  = e - 8'd120;
        mr  = {1'b0, q[22:20]} + {3'b000, q[19]};
        if (mag > F32_INF[30:0])
        begin
            r = {xs, E4M3_NAN};
        end
        else if (mag == F32_INF[30:0])
        begin
            r = {sg, E4M3_INF};
        end
        else if (mag == 31'd0)
        begin
            r = {sg, 7'd0};
        end
        else if (mag >= F32_240[30:0])
        begin
            r = {sg, E4M3_MAX};
        end
        else if (mag < F32_E4M3_MIN_NORM[30:0])
        begin
            // subnormal code, truncated
            if (shv >= 9'd24)
            begin
                r = {sg, 7'd0};
            end
            else
            begin
                r = {sg, 4'd0, 3'(m24 >> shv[4:0])};
            end
        end
        else
        begin
            if (mr[3])
            begin
                mr = 4'd0;
                e8 = e8 + 8'd1;
            end
            if (e8 > 8'd14)
            begin
                r = {sg, E4M3_MAX};
            end
            else
            begin
                r = {sg, e8[3:0], mr[2:0]};
            end
        end
        return r;
    endfunction

    fp8q_ram #(
        .WIDTH(32),
        .DEPTH(BLOCK_SIZE)
    ) u_store (
        .clk    (clk),
        .wr_en  (cmd.wr),
        .wr_addr(addr),
        .wr_data(value_bits),
        .rd_en  (cmd.rd),
        .rd_addr(addr),
        .rd_data(rd_data)
    );

    assign div_a = cmd.div_scale ? {1'b0, amax_reg} : rd_data;
    assign div_b = cmd.div_scale ? F32_240 : d_reg;

    fp8q_fdiv u_fdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .a     (div_a),
        .b     (div_b),
        .done  (div_done),
        .result(div_res)
    );

    assign code     = cmd.code_zero ? 8'd0 : enc_e4m3(div_res, rd_data[31]);
    assign byte_pos = {3'(slot), 3'b000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amax_reg <= 31'd0;
        end
        else if (cmd.clear_amax)
        begin
            amax_reg <= 31'd0;
        end
        else if (cmd.wr && (value_bits[30:0] <= F32_INF[30:0])
                 && (value_bits[30:0] > amax_reg))
        begin
            amax_reg <= value_bits[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_scale)
        begin
            d_reg <= (amax_reg == 31'd0) ? 32'd0 : div_res;
        end
        if (cmd.clear_packed)
        begin
            packed_reg <= 64'd0;
        end
        else if (cmd.code_wr)
        begin
            packed_reg[byte_pos +: 8] <= code;
        end
    end

    assign stat.div_done = div_done;
    assign stat.d_zero   = (d_reg == 32'd0);
    assign codes_packed  = packed_reg;
    assign scale_bits    = d_reg;

endmodule

@@ hw/rtl/fp8q_ctrl.sv @@
// controller: block fill, scale computation and group emission sequencing
module fp8q_ctrl #(
    parameter int BLOCK_SIZE = fp8q_pkg::BLOCK_SIZE_DEF,
    parameter int CODES_PER_RESULT = fp8q_pkg::CODES_PER_RESULT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_last,
    output fp8q_pkg::fp8q_cmd_t                 cmd,
    input  fp8q_pkg::fp8q_stat_t                stat,
    output logic [$clog2(BLOCK_SIZE)-1:0]       addr,
    output logic [((CODES_PER_RESULT > 1) ? $clog2(CODES_PER_RESULT) : 1)-1:0] slot
);
    import fp8q_pkg::*;

    localparam int AW = $clog2(BLOCK_SIZE);
    localparam int EW = $clog2(BLOCK_SIZE + CODES_PER_RESULT);
    localparam int KW = (CODES_PER_RESULT > 1) ? $clog2(CODES_PER_RESULT) : 1;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_SWAIT = 3'd2;
    localparam logic [2:0] S_ELEM  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [AW-1:0] fill_reg;
    logic [AW-1:0] fill_next;
    logic [EW-1:0] elem_reg;
    logic [EW-1:0] elem_next;
    logic [KW-1:0] slot_reg;
    logic [KW-1:0] slot_next;
    logic          advance;
    logic          elem_live;

    assign elem_live = (elem_reg < EW'(BLOCK_SIZE));
    assign out_last  = (elem_reg >= EW'(BLOCK_SIZE - 1));

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        elem_next  = elem_reg;
        slot_next  = slot_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        advance    = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.wr = 1'b1;
                    if (fill_reg == AW'(BLOCK_SIZE - 1))
                    begin
                        fill_next  = '0;
                        state_next = S_SCALE;
                    end
                    else
                    begin
                        fill_next = fill_reg + AW'(1);
                    end
                end
            end
            S_SCALE:
            begin
                cmd.div_start = 1'b1;
                cmd.div_scale = 1'b1;
                state_next    = S_SWAIT;
            end
            S_SWAIT:
            begin
                cmd.div_scale = 1'b1;
                if (stat.div_done)
                begin
                    cmd.load_scale   = 1'b1;
                    cmd.clear_packed = 1'b1;
                    elem_next        = '0;
                    slot_next        = '0;
                    state_next       = S_ELEM;
                end
            end
            S_ELEM:
            begin
                if (elem_live && !stat.d_zero)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    cmd.code_wr   = 1'b1;
                    cmd.code_zero = 1'b1;
                    advance       = 1'b1;
                end
            end
            S_RD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.code_wr = 1'b1;
                    advance     = 1'b1;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.clear_packed = 1'b1;
                    if (out_last)
                    begin
                        cmd.clear_amax = 1'b1;
                        state_next     = S_LOAD;
                    end
                    else
                    begin
                        elem_next  = elem_reg + EW'(1);
                        slot_next  = '0;
                        state_next = S_ELEM;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (advance)
        begin
            if (slot_reg == KW'(CODES_PER_RESULT - 1))
            begin
                state_next = S_OUT;
            end
            else
            begin
                slot_next  = slot_reg + KW'(1);
                elem_next  = elem_reg + EW'(1);
                state_next = S_ELEM;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            fill_reg  <= '0;
            elem_reg  <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            elem_reg  <= elem_next;
            slot_reg  <= slot_next;
        end
    end

    assign addr = (state_reg == S_LOAD) ? fill_reg : elem_reg[AW-1:0];
    assign slot = slot_reg;

`ifndef SYNTHESIS
    a_load_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input taken while a group is shown");

    a_rd_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> (elem_live && !stat.d_zero))
        else $error("sample read outside the block or with zero scale");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |-> (elem_reg < EW'(BLOCK_SIZE - 1)))
        else $error("last group flag missing");

    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> ((state_reg == S_SWAIT) || (state_reg == S_DIV)))
        else $error("divider finished with nobody waiting");
`endif

endmodule

@@ hw/rtl/fp8_e4m3_block_quantizer.sv @@
// top level of the fp8 e4m3 block absmax quantizer
// Values are taken one per cycle while a block of BLOCK_SIZE is filling; the beat that
// completes the block starts quantization and input stays stalled until every group of
// the block has been delivered. The block scale is amax/240 computed by an iterative fp32
// divider that resolves one quotient bit per cycle, and the same divider then produces
// each value/scale before e4m3 encoding; each group is then shown on the output until
// it is taken. With a zero scale the divider is skipped and a zero code is written.
module fp8_e4m3_block_quantizer #(
    parameter int BLOCK_SIZE = fp8q_pkg::BLOCK_SIZE_DEF,
    parameter int CODES_PER_RESULT = fp8q_pkg::CODES_PER_RESULT_DEF
) (
    input logic        clk,
    input logic        rst_n,
    fp8q_in_if.sink    values,
    fp8q_out_if.source codes
);
    import fp8q_pkg::*;

    localparam int AW = $clog2(BLOCK_SIZE);
    localparam int KW = (CODES_PER_RESULT > 1) ? $clog2(CODES_PER_RESULT) : 1;

    fp8q_cmd_t     cmd;
    fp8q_stat_t    stat;
    logic [AW-1:0] addr;
    logic [KW-1:0] slot;

    fp8q_ctrl #(
        .BLOCK_SIZE      (BLOCK_SIZE),
        .CODES_PER_RESULT(CODES_PER_RESULT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (values.valid),
        .in_ready (values.ready),
        .out_valid(codes.valid),
        .out_ready(codes.ready),
        .out_last (codes.last_of_block),
        .cmd      (cmd),
        .stat     (stat),
        .addr     (addr),
        .slot     (slot)
    );

    fp8q_datapath #(
        .BLOCK_SIZE      (BLOCK_SIZE),
        .CODES_PER_RESULT(CODES_PER_RESULT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .addr        (addr),
        .slot        (slot),
        .value_bits  (values.value_bits),
        .codes_packed(codes.codes_packed),
        .scale_bits  (codes.scale_bits)
    );

endmodule
